[rtl/core/modular_inverse_ext_euclid_defines.svh]
// Assertion macros shared by the modular inverse RTL.
`ifndef MODULAR_INVERSE_EXT_EUCLID_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define MIE_CHECK_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mie: same-cycle check failed");

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define MIE_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mie: next-cycle check failed");

`endif

[rtl/core/mie_pkg.sv]
// Shared types for the modular inverse block: sequencer states and divider status.
package mie_pkg;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_DIV   = 5'b00100,
      ST_UPD   = 5'b01000,
      ST_FIN   = 5'b10000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic rem_zero;
   } div_status_type;

endpackage

[rtl/core/mie_divider.sv]
// Shift-subtract divider that also accumulates two coefficient products.
`include "modular_inverse_ext_euclid_defines.svh"

module mie_divider #(
   parameter int WIDTH = 31
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [WIDTH-1:0]        dividend,
   input  logic [WIDTH-1:0]        divisor,
   input  logic [WIDTH:0]          coeff_a,
   input  logic [WIDTH:0]          coeff_b,
   output mie_pkg::div_status_type status,
   output logic [WIDTH-1:0]        rem,
   output logic [WIDTH:0]          acc_a,
   output logic [WIDTH:0]          acc_b
);

   localparam int CW = $clog2(WIDTH);
   localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

   logic [WIDTH:0]   rem_ff, rem_in, rem_sh;
   logic [WIDTH+1:0] diff;
   logic [WIDTH-1:0] dvd_ff;
   logic [WIDTH:0]   acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff, qbit;

   // One restoring-division step; the quotient bit also drives a Horner
   // accumulation of coeff * quotient, wrapping at WIDTH+1 bits.
   always_comb begin
      rem_sh   = {rem_ff[WIDTH-1:0], dvd_ff[WIDTH-1]};
      diff     = {1'b0, rem_sh} - {2'b00, divisor};
      qbit     = ~diff[WIDTH+1];
      rem_in   = qbit ? diff[WIDTH:0] : rem_sh;
      acc_a_in = {acc_a_ff[WIDTH-1:0], 1'b0} + (qbit ? coeff_a : '0);
      acc_b_in = {acc_b_ff[WIDTH-1:0], 1'b0} + (qbit ? coeff_b : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= '0;
         dvd_ff   <= dividend;
         acc_a_ff <= '0;
         acc_b_ff <= '0;
      end else if (busy_ff) begin
         rem_ff   <= rem_in;
         dvd_ff   <= {dvd_ff[WIDTH-2:0], 1'b0};
         acc_a_ff <= acc_a_in;
         acc_b_ff <= acc_b_in;
      end
   end

   assign status.busy     = busy_ff;
   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);
   assign rem             = rem_ff[WIDTH-1:0];
   assign acc_a           = acc_a_ff;
   assign acc_b           = acc_b_ff;

   `MIE_CHECK_NOW(a_done_not_busy, done_ff, !busy_ff)
   `MIE_CHECK_NEXT(a_done_pulse, done_ff, !done_ff)
   `MIE_CHECK_NOW(a_rem_below_divisor, done_ff, rem_ff < {1'b0, divisor})

endmodule

[rtl/core/modular_inverse_ext_euclid.sv]
// Top level of the extended Euclidean gcd and modular inverse block.
//
//   channel | direction | beat contents
//   --------+-----------+-----------------------------------------------------------
//   req_    | in        | operand_a, modulus
//   rsp_    | out       | gcd_value, coeff_x, coeff_y, inverse, has_inverse
//
// One beat is worked on at a time; req_ready is high only while the sequencer is idle.
// Each Euclid round passes the start state, WIDTH shift-subtract steps of the shared
// divider, the divider's done pulse and then the update state, or the finish state
// after the last round; a zero operand_a or modulus goes straight to the finish state.
// The result waits in an output register, so a stalled rsp_ channel only holds the
// sequencer in its finish state once the next result is ready.
// Reset is synchronous and clears the sequencer and the output valid flag.
`include "modular_inverse_ext_euclid_defines.svh"

module modular_inverse_ext_euclid #(
   parameter int WIDTH = 31
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [WIDTH-1:0]        req_operand_a,
   input  logic [WIDTH-1:0]        req_modulus,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [WIDTH-1:0]        rsp_gcd_value,
   output logic signed [WIDTH:0]   rsp_coeff_x,
   output logic signed [WIDTH:0]   rsp_coeff_y,
   output logic [WIDTH-1:0]        rsp_inverse,
   output logic                    rsp_has_inverse
);

   mie_pkg::state_type      state_ff, state_in;
   mie_pkg::div_status_type div_status;

   // Remainder pair and the Bezout coefficient pairs of the larger operand (x)
   // and the smaller operand (y).
   logic [WIDTH-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [WIDTH:0]   x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic             swap_ff, swap_in, nz_ff, nz_in;
   logic [WIDTH-1:0] mod_ff, mod_in;
   logic [WIDTH-1:0] res_g_ff, res_g_in;
   logic [WIDTH:0]   res_x_ff, res_x_in, res_y_ff, res_y_in;

   logic             rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [WIDTH-1:0] rsp_gcd_ff, rsp_inv_ff;
   logic [WIDTH:0]   rsp_x_ff, rsp_y_ff;
   logic             rsp_flag_ff;

   logic             div_start, accept;
   logic [WIDTH-1:0] div_rem;
   logic [WIDTH:0]   acc_x, acc_y;
   logic [WIDTH-1:0] inv_calc;
   logic             flag_calc;

   mie_divider #(.WIDTH(WIDTH)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (r0_ff),
      .divisor  (r1_ff),
      .coeff_a  (x1_ff),
      .coeff_b  (y1_ff),
      .status   (div_status),
      .rem      (div_rem),
      .acc_a    (acc_x),
      .acc_b    (acc_y)
   );

   assign req_ready = (state_ff == mie_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   // With gcd one, the coefficient of operand_a lies strictly between -modulus
   // and modulus, so folding it into [0, modulus) needs one add at most.
   assign flag_calc = nz_ff && (res_g_ff == WIDTH'(1));
   assign inv_calc  = res_x_ff[WIDTH] ? (mod_ff + res_x_ff[WIDTH-1:0]) : res_x_ff[WIDTH-1:0];

   always_comb begin
      state_in     = state_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      swap_in      = swap_ff;
      nz_in        = nz_ff;
      mod_in       = mod_ff;
      res_g_in     = res_g_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         mie_pkg::ST_IDLE: begin
            if (accept) begin
               mod_in = req_modulus;
               if (req_modulus == '0) begin
                  // Zero modulus: gcd is operand_a itself, no inverse.
                  res_g_in = req_operand_a;
                  res_x_in = (WIDTH+1)'(1);
                  res_y_in = '0;
                  nz_in    = 1'b0;
                  state_in = mie_pkg::ST_FIN;
               end else if (req_operand_a == '0) begin
                  res_g_in = req_modulus;
                  res_x_in = '0;
                  res_y_in = (WIDTH+1)'(1);
                  nz_in    = 1'b0;
                  state_in = mie_pkg::ST_FIN;
               end else begin
                  // Larger operand goes first; on a tie operand_a is the larger.
                  swap_in  = req_operand_a < req_modulus;
                  r0_in    = swap_in ? req_modulus : req_operand_a;
                  r1_in    = swap_in ? req_operand_a : req_modulus;
                  x0_in    = (WIDTH+1)'(1);
                  x1_in    = '0;
                  y0_in    = '0;
                  y1_in    = (WIDTH+1)'(1);
                  nz_in    = 1'b1;
                  state_in = mie_pkg::ST_START;
               end
            end
         end
         mie_pkg::ST_START: begin
            div_start = 1'b1;
            state_in  = mie_pkg::ST_DIV;
         end
         mie_pkg::ST_DIV: begin
            if (div_status.done) begin
               if (div_status.rem_zero) begin
                  // r1 divides r0: r1 is the gcd and (x1, y1) the coefficients.
                  res_g_in = r1_ff;
                  res_x_in = swap_ff ? y1_ff : x1_ff;
                  res_y_in = swap_ff ? x1_ff : y1_ff;
                  state_in = mie_pkg::ST_FIN;
               end else begin
                  state_in = mie_pkg::ST_UPD;
               end
            end
         end
         mie_pkg::ST_UPD: begin
            r0_in    = r1_ff;
            r1_in    = div_rem;
            x0_in    = x1_ff;
            x1_in    = x0_ff - acc_x;
            y0_in    = y1_ff;
            y1_in    = y0_ff - acc_y;
            state_in = mie_pkg::ST_START;
         end
         mie_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mie_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mie_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mie_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      x0_ff    <= x0_in;
      x1_ff    <= x1_in;
      y0_ff    <= y0_in;
      y1_ff    <= y1_in;
      swap_ff  <= swap_in;
      nz_ff    <= nz_in;
      mod_ff   <= mod_in;
      res_g_ff <= res_g_in;
      res_x_ff <= res_x_in;
      res_y_ff <= res_y_in;
      if (rsp_load) begin
         rsp_gcd_ff  <= res_g_ff;
         rsp_x_ff    <= res_x_ff;
         rsp_y_ff    <= res_y_ff;
         rsp_inv_ff  <= flag_calc ? inv_calc : '0;
         rsp_flag_ff <= flag_calc;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gcd_value   = rsp_gcd_ff;
   assign rsp_coeff_x     = $signed(rsp_x_ff);
   assign rsp_coeff_y     = $signed(rsp_y_ff);
   assign rsp_inverse     = rsp_inv_ff;
   assign rsp_has_inverse = rsp_flag_ff;

   `MIE_CHECK_NOW(a_div_nonzero, state_ff == mie_pkg::ST_DIV, r1_ff != '0)
   `MIE_CHECK_NOW(a_flag_gcd_one, rsp_valid_ff && rsp_flag_ff, rsp_gcd_ff == WIDTH'(1))
   `MIE_CHECK_NEXT(a_fin_holds, (state_ff == mie_pkg::ST_FIN) && rsp_valid_ff && !rsp_ready,
                   state_ff == mie_pkg::ST_FIN)

endmodule
